@@ rtl/core/rar_pkg.sv @@
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, operation codes and queue entry type for the rational
// arithmetic reducer.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int IN_W       = 16;
    localparam int PROD_W     = 2 * IN_W;
    localparam int RAW_W      = 2 * IN_W + 1;
    localparam int MAG_W      = RAW_W;
    localparam int K_W        = $clog2(MAG_W + 1);
    localparam int OUT_W      = 33;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_DIV_ZERO = 1'b1;

    typedef struct packed {
        logic [RAW_W-1:0] num;
        logic [RAW_W-1:0] den;
    } raw_t;

    typedef struct packed {
        logic push;
        logic full;
    } qctl_t;

endpackage

@@ rtl/core/rar_front.sv @@
// ----------------------------------------------------------------------------
// rar_front
// Accepts an operand beat, forms the cross products and pushes the raw
// numerator and denominator into the queue.
// ----------------------------------------------------------------------------
module rar_front
    import rar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       operation,
    input  logic [15:0]      num_a,
    input  logic [15:0]      den_a,
    input  logic [15:0]      num_b,
    input  logic [15:0]      den_b,
    input  logic             q_full,
    output logic             q_push,
    output raw_t             q_data
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

    fstate_t                   state_reg, state_next;
    logic [1:0]                op_reg;
    logic signed [IN_W-1:0]    na_reg, da_reg, nb_reg, db_reg;
    logic signed [PROD_W-1:0]  x_reg, y_reg, z_reg;
    logic signed [PROD_W-1:0]  x_next, y_next, z_next;
    logic signed [RAW_W-1:0]   xe, ye, num_raw, den_raw;

    assign in_stall = (state_reg != F_IDLE);

    always_comb
    begin
        x_next = na_reg * ((op_reg == OP_MUL) ? nb_reg : db_reg);
        y_next = nb_reg * da_reg;
        z_next = da_reg * ((op_reg == OP_DIV) ? nb_reg : db_reg);
    end

    always_comb
    begin
        xe      = RAW_W'(x_reg);
        ye      = RAW_W'(y_reg);
        den_raw = RAW_W'(z_reg);
        unique case (op_reg)
            OP_ADD:  num_raw = xe + ye;
            OP_SUB:  num_raw = xe - ye;
            default: num_raw = xe;
        endcase
    end

    assign q_push     = (state_reg == F_PUSH) && !q_full;
    assign q_data.num = num_raw;
    assign q_data.den = den_raw;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_MUL;
            F_MUL:  state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            op_reg <= operation;
            na_reg <= num_a[IN_W-1:0];
            da_reg <= den_a[IN_W-1:0];
            nb_reg <= num_b[IN_W-1:0];
            db_reg <= den_b[IN_W-1:0];
        end
        if (state_reg == F_MUL)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

@@ rtl/core/rar_fifo.sv @@
// ----------------------------------------------------------------------------
// rar_fifo
// Short queue of raw pairs between front and back.
// ----------------------------------------------------------------------------
module rar_fifo
    import rar_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  qctl_t ctl_in,
    input  raw_t  wr_data,
    input  logic  pop,
    output logic  empty,
    output raw_t  rd_data
);

    raw_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (ctl_in.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctl_in.push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (ctl_in.push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !ctl_in.push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.push |-> !ctl_in.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.full == (count_reg == CNT_W'(FIFO_DEPTH)))
        else $error("full flag out of step with count");

endmodule

@@ rtl/core/rar_back.sv @@
// ----------------------------------------------------------------------------
// rar_back
// Takes a raw pair, finds the gcd of the magnitudes by binary steps, divides
// both by it one quotient bit a cycle and holds the result in the output
// register.
// ----------------------------------------------------------------------------
module rar_back
    import rar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  raw_t             q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [OUT_W-1:0] result_num,
    output logic [OUT_W-1:0] result_den,
    output logic             status
);

    typedef enum logic [1:0] {B_IDLE, B_GCD, B_DIV, B_OUT} bstate_t;

    bstate_t             state_reg, state_next;
    logic [MAG_W-1:0]    a_reg, a_next, b_reg, b_next, g_reg, g_next;
    logic [K_W-1:0]      k_reg, k_next, cnt_reg, cnt_next;
    logic [MAG_W-1:0]    qn_reg, qn_next, qd_reg, qd_next;
    logic [MAG_W-1:0]    rn_reg, rn_next, rd_reg, rd_next;
    logic                negn_reg, negn_next, negd_reg, negd_next;
    logic                zden_reg, zden_next;
    logic                ov_reg, ov_next, st_reg, st_next;
    logic [OUT_W-1:0]    onum_reg, onum_next, oden_reg, oden_next;
    logic [MAG_W-1:0]    mag_n, mag_d;
    logic [MAG_W:0]      rsn, rsd;
    logic                gen, ged;
    logic [OUT_W-1:0]    qn_o, qd_o;

    assign q_pop      = (state_reg == B_IDLE) && !q_empty;
    assign out_valid  = ov_reg;
    assign result_num = onum_reg;
    assign result_den = oden_reg;
    assign status     = st_reg;

    always_comb
    begin
        mag_n = q_data.num[RAW_W-1] ? (~q_data.num + 1'b1) : q_data.num;
        mag_d = q_data.den[RAW_W-1] ? (~q_data.den + 1'b1) : q_data.den;
        rsn   = {rn_reg, qn_reg[MAG_W-1]};
        rsd   = {rd_reg, qd_reg[MAG_W-1]};
        gen   = (rsn >= {1'b0, g_reg});
        ged   = (rsd >= {1'b0, g_reg});
        qn_o  = OUT_W'(qn_reg);
        qd_o  = OUT_W'(qd_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        g_next     = g_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        qn_next    = qn_reg;
        qd_next    = qd_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        negn_next  = negn_reg;
        negd_next  = negd_reg;
        zden_next  = zden_reg;
        ov_next    = ov_reg && out_stall;
        st_next    = st_reg;
        onum_next  = onum_reg;
        oden_next  = oden_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    negn_next = q_data.num[RAW_W-1];
                    negd_next = q_data.den[RAW_W-1];
                    a_next    = mag_n;
                    b_next    = mag_d;
                    g_next    = mag_d;
                    k_next    = '0;
                    cnt_next  = '0;
                    qn_next   = mag_n;
                    qd_next   = mag_d;
                    rn_next   = '0;
                    rd_next   = '0;
                    zden_next = (q_data.den == '0);
                    if (q_data.den == '0)
                        state_next = B_OUT;
                    else if (q_data.num == '0)
                        state_next = B_DIV;
                    else
                        state_next = B_GCD;
                end
            end
            B_GCD:
            begin
                priority if (a_reg == b_reg)
                begin
                    g_next     = a_reg << k_reg;
                    state_next = B_DIV;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!a_reg[0])
                    a_next = a_reg >> 1;
                else if (!b_reg[0])
                    b_next = b_reg >> 1;
                else if (a_reg > b_reg)
                    a_next = (a_reg - b_reg) >> 1;
                else
                    b_next = (b_reg - a_reg) >> 1;
            end
            B_DIV:
            begin
                rn_next  = gen ? MAG_W'(rsn - {1'b0, g_reg}) : rsn[MAG_W-1:0];
                rd_next  = ged ? MAG_W'(rsd - {1'b0, g_reg}) : rsd[MAG_W-1:0];
                qn_next  = {qn_reg[MAG_W-2:0], gen};
                qd_next  = {qd_reg[MAG_W-2:0], ged};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == K_W'(MAG_W - 1))
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    state_next = B_IDLE;
                    if (zden_reg)
                    begin
                        onum_next = '0;
                        oden_next = '0;
                        st_next   = ST_DIV_ZERO;
                    end
                    else
                    begin
                        onum_next = negn_reg ? (~qn_o + 1'b1) : qn_o;
                        oden_next = negd_reg ? (~qd_o + 1'b1) : qd_o;
                        st_next   = ST_OK;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
            a_reg     <= '0;
            b_reg     <= '0;
            g_reg     <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
            qn_reg    <= '0;
            qd_reg    <= '0;
            rn_reg    <= '0;
            rd_reg    <= '0;
            negn_reg  <= 1'b0;
            negd_reg  <= 1'b0;
            zden_reg  <= 1'b0;
            st_reg    <= ST_OK;
            onum_reg  <= '0;
            oden_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            g_reg     <= g_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            qn_reg    <= qn_next;
            qd_reg    <= qd_next;
            rn_reg    <= rn_next;
            rd_reg    <= rd_next;
            negn_reg  <= negn_next;
            negd_reg  <= negd_next;
            zden_reg  <= zden_next;
            st_reg    <= st_next;
            onum_reg  <= onum_next;
            oden_reg  <= oden_next;
        end
    end

endmodule

@@ rtl/core/rational_arith_reduce.sv @@
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by the gcd of numerator and denominator magnitudes.
// A zero denominator skips the gcd and the divider and gives ST_DIV_ZERO
// status with a zero payload; a zero numerator skips only the gcd steps.
// The back takes a new beat only after putting out the last; the front
// takes one only after pushing the last, while the 2-entry queue has room.
// Reset: rst_n asynchronous active low, clears queue, state and out_valid.
// ----------------------------------------------------------------------------
module rational_arith_reduce
    import rar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [15:0]       num_a,
    input  logic [15:0]       den_a,
    input  logic [15:0]       num_b,
    input  logic [15:0]       den_b,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  result_num,
    output logic [OUT_W-1:0]  result_den,
    output logic              status
);

    qctl_t qctl;
    raw_t  wr_data, rd_data;
    logic  q_empty, q_pop;
    logic  full_flag;

    rar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .q_full    (full_flag),
        .q_push    (qctl.push),
        .q_data    (wr_data)
    );

    rar_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (qctl),
        .wr_data (wr_data),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (rd_data)
    );

    logic [CNT_W-1:0] fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (qctl.push && !q_pop)
        begin
            fill_reg <= fill_reg + 1'b1;
        end
        else if (q_pop && !qctl.push)
        begin
            fill_reg <= fill_reg - 1'b1;
        end
    end

    assign full_flag = (fill_reg == CNT_W'(FIFO_DEPTH));
    assign qctl.full = full_flag;

    rar_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (rd_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_num (result_num),
        .result_den (result_den),
        .status     (status)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_DIV_ZERO) |-> (result_num == '0 && result_den == '0))
        else $error("error beat with non-zero payload");
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (result_den != '0))
        else $error("ok beat with zero denominator");
    a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK && result_num == '0)
            |-> (result_den == OUT_W'(1) || result_den == '1))
        else $error("zero numerator not over unit denominator");

endmodule

@@ dv/tb_rational_arith_reduce.sv @@
// ----------------------------------------------------------------------------
// tb_rational_arith_reduce
// Self-checking bench for the rational arithmetic reducer: directed corner
// beats, then random fractions under varying sender gaps and receiver stalls,
// each result checked against a gcd-reduction predictor.
// ----------------------------------------------------------------------------
module tb_rational_arith_reduce;
    import rar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [OUT_W-1:0] num;
        logic [OUT_W-1:0] den;
        logic             st;
    } frac_t;

    class frac_scoreboard;
        frac_t pending[$];
        int    mismatches;

        function longint unsigned magnitude(longint x);
            return (x < 0) ? longint'(-x) : longint'(x);
        endfunction

        function void note_beat(logic [1:0] op, logic [15:0] na16, logic [15:0] da16,
                                logic [15:0] nb16, logic [15:0] db16);
            longint na, da, nb, db, rn, rd;
            longint unsigned a, b, t;
            frac_t e;
            na = longint'($signed(na16));
            da = longint'($signed(da16));
            nb = longint'($signed(nb16));
            db = longint'($signed(db16));
            case (op)
                OP_ADD: begin rn = na * db + nb * da; rd = da * db; end
                OP_SUB: begin rn = na * db - nb * da; rd = da * db; end
                OP_MUL: begin rn = na * nb; rd = da * db; end
                default: begin rn = na * db; rd = da * nb; end
            endcase
            if (rd == 0)
            begin
                e.num = '0;
                e.den = '0;
                e.st  = ST_DIV_ZERO;
            end
            else
            begin
                a = magnitude(rn);
                b = magnitude(rd);
                if (a == 0)
                    a = b;
                else
                    while (b != 0)
                    begin
                        t = a % b;
                        a = b;
                        b = t;
                    end
                rn = rn / longint'(a);
                rd = rd / longint'(a);
                e.num = rn[OUT_W-1:0];
                e.den = rd[OUT_W-1:0];
                e.st  = ST_OK;
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [OUT_W-1:0] n, logic [OUT_W-1:0] d, logic s);
            frac_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h/%h st %b", n, d, s);
                return;
            end
            e = pending.pop_front();
            if (n !== e.num || d !== e.den || s !== e.st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h/%h st %b, got %h/%h st %b",
                             e.num, e.den, e.st, n, d, s);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        operation;
    logic [15:0]       num_a, den_a, num_b, den_b;
    logic              out_valid;
    logic              out_stall;
    logic [OUT_W-1:0]  result_num, result_den;
    logic              status;

    frac_scoreboard sb;
    int  send_idle_pct;
    int  stall_pct;
    int  idle_cycles;
    bit  timed_out;

    rational_arith_reduce DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
                sb.check_result(result_num, result_den, status);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
        if (idle_cycles >= 5000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end

    task automatic send_frac(logic [1:0] op, logic [15:0] na, logic [15:0] da,
                             logic [15:0] nb, logic [15:0] db);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        num_a     <= na;
        den_a     <= da;
        num_b     <= nb;
        den_b     <= db;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(op, na, da, nb, db);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(16)) - 8);
            3: return 16'($urandom_range(255)) << $urandom_range(8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        logic [15:0] na, da, nb, db;
        logic [1:0]  op;
        for (int i = 0; i < count; i++)
        begin
            op = 2'($urandom_range(3));
            na = rand_field();
            nb = ($urandom_range(19) == 0) ? 16'h0000 : rand_field();
            do da = rand_field(); while (da == 0);
            do db = rand_field(); while (db == 0);
            send_frac(op, na, da, nb, db);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        operation = OP_ADD;
        num_a = '0; den_a = 16'd1; num_b = '0; den_b = 16'd1;
        send_idle_pct = 0;
        stall_pct = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_frac(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_frac(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_frac(OP_MUL, 16'd2, 16'd4, 16'd3, 16'd9);
        send_frac(OP_DIV, 16'd1, 16'd2, 16'd3, 16'd4);
        send_frac(OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3);
        send_frac(OP_DIV, 16'd0, 16'd7, 16'd0, 16'hffff);
        send_frac(OP_MUL, 16'd0, 16'hfffd, 16'd5, 16'd2);
        send_frac(OP_ADD, 16'd1, 16'hfffe, 16'd0, 16'd1);
        send_frac(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_frac(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_frac(OP_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_frac(OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_frac(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_frac(OP_SUB, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_frac(OP_MUL, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
        send_frac(OP_DIV, 16'h8000, 16'h0001, 16'h0000, 16'hffff);
        send_frac(OP_ADD, 16'd0, 16'd5, 16'd0, 16'hfff9);
        drain();

        send_random(200);
        send_idle_pct = 55;
        send_random(180);
        drain();
        send_idle_pct = 0;
        stall_pct = 55;
        send_random(180);
        send_idle_pct = 7;
        stall_pct = 7;
        send_random(180);

        drain();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
